// File: design/vrhb_pkg.sv
// ----------------------------------------------------------------------------
// vrhb_pkg
// Shared types and constants of the variable record history buffer.
// ----------------------------------------------------------------------------
package vrhb_pkg;

  localparam int BUF_BYTES = 1024;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int USED_W    = ADDR_W + 1;
  localparam int WALK_W    = USED_W + 1;
  localparam int MAX_ENTRY = 64;
  localparam int HDR_BYTES = 2;
  localparam int LEN_W     = 7;
  localparam int STG_W     = $clog2(MAX_ENTRY);
  localparam int IDX_W     = 10;
  localparam int EV_W      = 10;

  localparam logic [2:0] CMD_PUSH_START = 3'd0;
  localparam logic [2:0] CMD_PUSH_BYTE  = 3'd1;
  localparam logic [2:0] CMD_POP        = 3'd2;
  localparam logic [2:0] CMD_GET        = 3'd3;
  localparam logic [2:0] CMD_REMOVE     = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_NO_PUSH  = 2'd3;

  typedef enum logic [2:0] {
    OP_START,
    OP_BYTE,
    OP_POP,
    OP_GET,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] lim;
  } item_t;

  typedef struct packed {
    logic [7:0]       byte_value;
    logic             byte_valid;
    logic             last;
    logic [LEN_W-1:0] record_length;
    logic [EV_W-1:0]  evicted_count;
    logic [1:0]       status;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EMIT,
    S_POP_HDR,
    S_REM_HDR,
    S_GET_CHK,
    S_GET_HDR,
    S_GET_LEN,
    S_ST_RD,
    S_ST_OUT,
    S_COMMIT,
    S_EV_RD,
    S_EV_CHK,
    S_WR_H0,
    S_WR_H1,
    S_WR_P,
    S_WR_DONE
  } eng_state_t;

endpackage

// File: design/vrhb_front.sv
// ----------------------------------------------------------------------------
// vrhb_front
// Accepts commands, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module vrhb_front import vrhb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       command,
  input  logic [LEN_W-1:0] entry_length,
  input  logic [7:0]       data_byte,
  input  logic [IDX_W-1:0] entry_index,
  input  logic [LEN_W-1:0] pop_limit,
  output logic             op_valid,
  output item_t            op_item,
  input  logic             op_take
);

  item_t       q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        known;
  op_t         op;
  logic        enq;
  logic        deq;

  // Unused command codes are accepted and dropped here; they cause no result.
  always_comb begin
    known = 1'b1;
    op    = OP_START;
    unique case (command)
      CMD_PUSH_START: op = OP_START;
      CMD_PUSH_BYTE:  op = OP_BYTE;
      CMD_POP:        op = OP_POP;
      CMD_GET:        op = OP_GET;
      CMD_REMOVE:     op = OP_REMOVE;
      default:        known = 1'b0;
    endcase
  end

  assign full     = (count == 2'd2);
  assign enq      = push && !full && known;
  assign deq      = op_take && op_valid;
  assign op_valid = (count != 2'd0);
  assign op_item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= '{op: op, len: entry_length, data: data_byte,
                     idx: entry_index, lim: pop_limit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) wr_ptr <= ~wr_ptr;
      if (deq) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

// File: design/vrhb_out_fifo.sv
// ----------------------------------------------------------------------------
// vrhb_out_fifo
// Four-entry result queue between the engine and the result port.
// ----------------------------------------------------------------------------
module vrhb_out_fifo import vrhb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  output logic    full,
  output logic    empty,
  input  logic    rd_en,
  output result_t rd_data
);

  result_t     mem [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic        do_wr;
  logic        do_rd;

  assign full    = (count == 3'd4);
  assign empty   = (count == 3'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 2'd1;
      if (do_rd) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, do_wr} - {2'b0, do_rd};
    end
  end

endmodule

// File: design/vrhb_engine.sv
// ----------------------------------------------------------------------------
// vrhb_engine
// Executes decoded commands against the circular record store.
// ----------------------------------------------------------------------------
module vrhb_engine import vrhb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [USED_W-1:0] cfg_data,
  input  logic              op_valid,
  input  item_t             op_item,
  output logic              op_take,
  output logic              of_push,
  output result_t           of_data,
  input  logic              of_full
);

  logic [7:0] store   [BUF_BYTES];
  logic [7:0] staging [MAX_ENTRY];
  logic [7:0] store_rdata;
  logic [7:0] stg_rdata;

  eng_state_t        state, state_next;
  logic [ADDR_W-1:0] head, head_next;
  logic [USED_W-1:0] used, used_next;
  logic [USED_W-1:0] cap;
  logic [LEN_W-1:0]  stg_count, stg_count_next;
  logic [LEN_W-1:0]  stg_target, stg_target_next;
  logic              push_open, push_open_next;
  item_t             cur, cur_next;
  logic [WALK_W-1:0] walk, walk_next;
  logic [USED_W-1:0] keep_end, keep_end_next;
  logic [EV_W-1:0]   ev, ev_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [ADDR_W-1:0] sbase, sbase_next;
  logic [LEN_W-1:0]  si, si_next;
  logic [LEN_W-1:0]  sn, sn_next;
  logic [LEN_W-1:0]  slen, slen_next;
  logic [ADDR_W-1:0] whead, whead_next;
  logic [STG_W-1:0]  wi, wi_next;
  result_t           res, res_next;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              stg_we;
  logic [STG_W-1:0]  stg_waddr;
  logic [STG_W-1:0]  stg_raddr;

  logic [USED_W-1:0] capn;
  logic [USED_W-1:0] need;
  logic [USED_W-1:0] limit;
  logic [LEN_W-1:0]  rl;
  logic [USED_W-1:0] drop_n;
  logic [WALK_W-1:0] next_walk;
  logic              walk_in;

  localparam result_t RES_ZERO = '0;

  assign capn      = (cap > USED_W'(BUF_BYTES)) ? USED_W'(BUF_BYTES) : cap;
  assign need      = USED_W'(stg_target) + USED_W'(HDR_BYTES);
  assign limit     = capn - need;
  assign rl        = store_rdata[LEN_W-1:0];
  assign next_walk = walk + WALK_W'(rl) + WALK_W'(HDR_BYTES);
  assign walk_in   = (walk < WALK_W'(used));

  always_comb begin
    drop_n = USED_W'(rl) + USED_W'(HDR_BYTES);
    if (drop_n > used) drop_n = used;
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) store_rdata <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stg_we) staging[stg_waddr] <= cur_next.data;
    stg_rdata <= staging[stg_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      used       <= '0;
      cap        <= USED_W'(BUF_BYTES);
      stg_count  <= '0;
      stg_target <= '0;
      push_open  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      used       <= used_next;
      stg_count  <= stg_count_next;
      stg_target <= stg_target_next;
      push_open  <= push_open_next;
      if (cfg_write) cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    walk     <= walk_next;
    keep_end <= keep_end_next;
    ev       <= ev_next;
    idx      <= idx_next;
    sbase    <= sbase_next;
    si       <= si_next;
    sn       <= sn_next;
    slen     <= slen_next;
    whead    <= whead_next;
    wi       <= wi_next;
    res      <= res_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    used_next       = used;
    stg_count_next  = stg_count;
    stg_target_next = stg_target;
    push_open_next  = push_open;
    cur_next        = cur;
    walk_next       = walk;
    keep_end_next   = keep_end;
    ev_next         = ev;
    idx_next        = idx;
    sbase_next      = sbase;
    si_next         = si;
    sn_next         = sn;
    slen_next       = slen;
    whead_next      = whead;
    wi_next         = wi;
    res_next        = res;
    op_take         = 1'b0;
    of_push         = 1'b0;
    of_data         = res;
    rd_en           = 1'b0;
    rd_addr         = head;
    wr_en           = 1'b0;
    wr_addr         = whead;
    wr_data         = '0;
    stg_we          = 1'b0;
    stg_waddr       = stg_count[STG_W-1:0];
    stg_raddr       = '0;

    unique case (state)
      S_IDLE: begin
        if (op_valid) begin
          op_take  = 1'b1;
          cur_next = op_item;
          res_next = RES_ZERO;
          res_next.last = 1'b1;
          unique case (op_item.op)
            OP_START: begin
              push_open_next  = 1'b0;
              stg_count_next  = '0;
              stg_target_next = '0;
              state_next      = S_EMIT;
              if (op_item.len > LEN_W'(MAX_ENTRY) ||
                  USED_W'(op_item.len) + USED_W'(HDR_BYTES) > capn) begin
                res_next.status = ST_TOO_LONG;
              end else begin
                stg_target_next = op_item.len;
                push_open_next  = 1'b1;
                if (op_item.len == '0) state_next = S_COMMIT;
              end
            end
            OP_BYTE: begin
              state_next = S_EMIT;
              if (!push_open) begin
                res_next.status = ST_NO_PUSH;
              end else begin
                stg_we         = 1'b1;
                stg_count_next = stg_count + LEN_W'(1);
                if (stg_count + LEN_W'(1) >= stg_target) state_next = S_COMMIT;
              end
            end
            OP_POP, OP_REMOVE: begin
              if (used == '0) begin
                res_next.status = ST_EMPTY;
                state_next      = S_EMIT;
              end else begin
                rd_en      = 1'b1;
                state_next = (op_item.op == OP_POP) ? S_POP_HDR : S_REM_HDR;
              end
            end
            OP_GET: begin
              walk_next  = '0;
              idx_next   = op_item.idx;
              state_next = S_GET_CHK;
            end
          endcase
        end
      end

      S_EMIT: begin
        if (!of_full) begin
          of_push    = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_POP_HDR: begin
        slen_next  = rl;
        sn_next    = (rl < cur.lim) ? rl : cur.lim;
        si_next    = '0;
        sbase_next = head + ADDR_W'(HDR_BYTES);
        head_next  = head + drop_n[ADDR_W-1:0];
        used_next  = used - drop_n;
        res_next.record_length = rl;
        if (rl == '0 || cur.lim == '0) state_next = S_EMIT;
        else state_next = S_ST_RD;
      end

      S_REM_HDR: begin
        head_next  = head + drop_n[ADDR_W-1:0];
        used_next  = used - drop_n;
        state_next = S_EMIT;
      end

      S_GET_CHK: begin
        rd_addr = head + walk[ADDR_W-1:0];
        if (walk_in) rd_en = 1'b1;
        if (idx != '0 && walk_in) begin
          state_next = S_GET_HDR;
        end else if (idx != '0 || !walk_in) begin
          res_next.status = ST_EMPTY;
          state_next      = S_EMIT;
        end else begin
          state_next = S_GET_LEN;
        end
      end

      S_GET_HDR: begin
        walk_next  = next_walk;
        idx_next   = idx - IDX_W'(1);
        state_next = S_GET_CHK;
      end

      S_GET_LEN: begin
        slen_next  = rl;
        sn_next    = rl;
        si_next    = '0;
        sbase_next = head + walk[ADDR_W-1:0] + ADDR_W'(HDR_BYTES);
        res_next.record_length = rl;
        state_next = (rl == '0) ? S_EMIT : S_ST_RD;
      end

      S_ST_RD: begin
        rd_en      = 1'b1;
        rd_addr    = sbase + ADDR_W'(si);
        state_next = S_ST_OUT;
      end

      S_ST_OUT: begin
        of_data = '{byte_value: store_rdata, byte_valid: 1'b1,
                    last: (si + LEN_W'(1) == sn), record_length: slen,
                    evicted_count: '0, status: ST_OK};
        if (!of_full) begin
          of_push = 1'b1;
          si_next = si + LEN_W'(1);
          state_next = (si + LEN_W'(1) == sn) ? S_IDLE : S_ST_RD;
        end
      end

      S_COMMIT: begin
        push_open_next = 1'b0;
        walk_next      = '0;
        keep_end_next  = '0;
        ev_next        = '0;
        whead_next     = head - need[ADDR_W-1:0];
        if (need > capn) begin
          res_next.status = ST_TOO_LONG;
          state_next      = S_EMIT;
        end else if (used + need <= capn) begin
          state_next = S_WR_H0;
        end else begin
          state_next = S_EV_RD;
        end
      end

      S_EV_RD: begin
        rd_en      = 1'b1;
        rd_addr    = head + walk[ADDR_W-1:0];
        state_next = S_EV_CHK;
      end

      // Records that end within the room left for the new one are kept;
      // every record past that point is evicted.
      S_EV_CHK: begin
        walk_next = next_walk;
        if (next_walk <= WALK_W'(limit)) keep_end_next = next_walk[USED_W-1:0];
        else ev_next = ev + EV_W'(1);
        if (next_walk < WALK_W'(used)) begin
          state_next = S_EV_RD;
        end else begin
          used_next  = (next_walk <= WALK_W'(limit)) ? next_walk[USED_W-1:0] : keep_end;
          state_next = S_WR_H0;
        end
      end

      S_WR_H0: begin
        wr_en      = 1'b1;
        wr_addr    = whead;
        wr_data    = {1'b0, stg_target};
        state_next = S_WR_H1;
      end

      S_WR_H1: begin
        wr_en      = 1'b1;
        wr_addr    = whead + ADDR_W'(1);
        wr_data    = '0;
        stg_raddr  = '0;
        wi_next    = '0;
        state_next = (stg_target == '0) ? S_WR_DONE : S_WR_P;
      end

      S_WR_P: begin
        wr_en     = 1'b1;
        wr_addr   = whead + ADDR_W'(HDR_BYTES) + ADDR_W'(wi);
        wr_data   = stg_rdata;
        stg_raddr = wi + STG_W'(1);
        wi_next   = wi + STG_W'(1);
        if (LEN_W'(wi) + LEN_W'(1) == stg_target) state_next = S_WR_DONE;
      end

      S_WR_DONE: begin
        head_next  = whead;
        used_next  = used + need;
        res_next.evicted_count = ev;
        state_next = S_EMIT;
      end

      default: state_next = S_IDLE;
    endcase
  end

  a_used_in_range: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(BUF_BYTES))
    else $error("used byte count exceeds the store size");

  a_staging_open: assert property (@(posedge clk) disable iff (rst)
    (push_open && state == S_IDLE) |-> (stg_count < stg_target))
    else $error("open push already holds all of its bytes");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(of_push && of_full))
    else $error("result written into a full result queue");

  a_fit_after_commit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_DONE) |=> (used <= capn || $past(used) == '0))
    else $error("committed record does not fit the capacity");

endmodule

// File: design/variable_record_history_buffer.sv
// ----------------------------------------------------------------------------
// variable_record_history_buffer
// History store of variable-length records with oldest-record eviction.
// ----------------------------------------------------------------------------
// Commands enter through a queue-like port: a transaction is taken when push
// is high and full is low. Results leave the same way: the oldest result is
// on the result ports while empty is low and is taken when pop is high.
// A two-entry command queue in front and a four-entry result queue behind
// let the sender and receiver stall independently of the engine.
// A commit copies the record into the store; when eviction is needed it
// first walks every stored header. Pop and get read the record out one
// byte at a time, and get walks every header it skips; all of this is set
// by the single read port of the byte store. The user must write capacity
// through cfg_write/cfg_data only while the block is idle; the block itself
// does not enforce this. Reset empties the store and closes any open push;
// it is synchronous. When the receiver stalls the result queue fills and
// the engine waits.
// ----------------------------------------------------------------------------
module variable_record_history_buffer import vrhb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        command,
  input  logic [LEN_W-1:0]  entry_length,
  input  logic [7:0]        data_byte,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [LEN_W-1:0]  pop_limit,
  input  logic              cfg_write,
  input  logic [USED_W-1:0] cfg_data,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        byte_value,
  output logic              byte_valid,
  output logic              last,
  output logic [LEN_W-1:0]  record_length,
  output logic [EV_W-1:0]   evicted_count,
  output logic [1:0]        status
);

  logic    op_valid;
  item_t   op_item;
  logic    op_take;
  logic    of_push;
  result_t of_data;
  logic    of_full;
  result_t out_data;

  vrhb_front u_front (
    .clk, .rst, .push, .full, .command, .entry_length, .data_byte,
    .entry_index, .pop_limit, .op_valid, .op_item, .op_take
  );

  vrhb_engine u_engine (
    .clk, .rst, .cfg_write, .cfg_data, .op_valid, .op_item, .op_take,
    .of_push, .of_data, .of_full
  );

  vrhb_out_fifo u_out (
    .clk, .rst, .wr_en(of_push), .wr_data(of_data), .full(of_full),
    .empty, .rd_en(pop), .rd_data(out_data)
  );

  assign byte_value    = out_data.byte_value;
  assign byte_valid    = out_data.byte_valid;
  assign last          = out_data.last;
  assign record_length = out_data.record_length;
  assign evicted_count = out_data.evicted_count;
  assign status        = out_data.status;

endmodule
